// File: hw/rtl/ssp_pkg.sv
package ssp_pkg;

  localparam int unsigned AXES      = 3;
  localparam int unsigned DIMS      = 3;   // axes at and above this read as zero
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned RAD_W     = 31;
  localparam int unsigned SQ_W      = 64;  // exact squared norm
  localparam int unsigned RSQ_W     = 2 * RAD_W;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned PROD_W    = RAD_W + COORD_W;
  localparam int unsigned QUO_W     = 31;  // quotient never exceeds the radius

  localparam logic [RAD_W-1:0] RESET_RADIUS = RAD_W'(64'd1 << FRAC_BITS);

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t [AXES-1:0] mag;
    logic   [AXES-1:0] neg;
    logic              in_sphere;
    logic              center;
  } side_t;

endpackage

// File: hw/rtl/sphere_surface_project.sv
// channel   dir  tdata (low bit up)                         tuser (low bit up)
// s_axis    in   pos_x[31:0] pos_y[63:32] pos_z[95:64]      -
// m_axis    out  surf_x[31:0] surf_y[63:32] surf_z[95:64]   is_inside[0] at_center[1]
// cfg       in   cfg_wdata_i = sphere_radius (unsigned Q15.16, 31 bits)
//
// One beat in per cycle, one beat out per cycle, unless the output beat is held; pipeline:
// 3 norm stages, 32 square-root stages (one root bit each), 1 multiply stage,
// 31 divider stages (one quotient bit each), 1 output register.
// Reset clears all valid bits and sets the radius to 1.0.
// A held output beat freezes the whole pipeline; tready goes low only then.
module sphere_surface_project (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ssp_pkg::RAD_W-1:0]   cfg_wdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [95:0]                 s_axis_tdata_i,   // pos_x, pos_y, pos_z
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [95:0]                 m_axis_tdata_o,   // surf_x, surf_y, surf_z
  output logic [1:0]                  m_axis_tuser_o    // is_inside, at_center
);
  import ssp_pkg::*;

  localparam int unsigned SIDE_W = $bits(side_t);

  logic [RAD_W-1:0] rad_q;
  logic             en;

  // global advance: move when the output slot is free or being taken
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= RESET_RADIUS;
    end else if (cfg_we_i) begin
      rad_q <= cfg_wdata_i;
    end
  end

  // squared norm, inside test, magnitudes
  coord_t [AXES-1:0] pos;
  logic              nrm_vld;
  logic [SQ_W-1:0]   nrm_n2;
  side_t             nrm_side;

  for (genvar i = 0; i < AXES; i++) begin : g_pos
    assign pos[i] = s_axis_tdata_i[i*COORD_W +: COORD_W];
  end

  ssp_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .pos_i   (pos),
    .rad_i   (rad_q),
    .valid_o (nrm_vld),
    .n2_o    (nrm_n2),
    .side_o  (nrm_side)
  );

  // floored square root
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [SIDE_W-1:0] sq_tag;
  side_t             sq_side;

  ssp_sqrt #(.TAG_W(SIDE_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nrm_vld),
    .rad_i   (nrm_n2),
    .tag_i   (nrm_side),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );
  assign sq_side = side_t'(sq_tag);

  // radius * |coord|
  logic [AXES-1:0][PROD_W-1:0] prod_q;
  logic [ROOT_W-1:0]           norm_q;
  side_t                       mul_side_q;
  logic                        mul_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (en) begin
      mul_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        prod_q[i] <= PROD_W'(rad_q) * PROD_W'(sq_side.mag[i]);
      end
      norm_q     <= sq_root;
      mul_side_q <= sq_side;
    end
  end

  // truncating divide, one unit per axis; axis 0 carries the flags
  logic [AXES-1:0]            dv_vld;
  logic [AXES-1:0][QUO_W-1:0] dv_quo;
  logic [2:0]                 dv_tag0;
  logic [AXES-1:0]            dv_neg;

  ssp_div #(.TAG_W(3)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (mul_vld_q),
    .dividend_i (prod_q[0]),
    .divisor_i  (norm_q),
    .tag_i      ({mul_side_q.center, mul_side_q.in_sphere, mul_side_q.neg[0]}),
    .valid_o    (dv_vld[0]),
    .quo_o      (dv_quo[0]),
    .tag_o      (dv_tag0)
  );
  assign dv_neg[0] = dv_tag0[0];

  for (genvar i = 1; i < AXES; i++) begin : g_div
    ssp_div #(.TAG_W(1)) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (mul_vld_q),
      .dividend_i (prod_q[i]),
      .divisor_i  (norm_q),
      .tag_i      (mul_side_q.neg[i]),
      .valid_o    (dv_vld[i]),
      .quo_o      (dv_quo[i]),
      .tag_o      (dv_neg[i])
    );
  end

  // sign restore and output register; the origin forces zeros
  logic [95:0] out_data_q;
  logic [1:0]  out_user_q;
  logic        out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= &dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        if (dv_tag0[2]) begin
          out_data_q[i*COORD_W +: COORD_W] <= '0;
        end else if (dv_neg[i]) begin
          out_data_q[i*COORD_W +: COORD_W] <= COORD_W'(-{1'b0, dv_quo[i]});
        end else begin
          out_data_q[i*COORD_W +: COORD_W] <= {1'b0, dv_quo[i]};
        end
      end
      out_user_q <= {dv_tag0[2], dv_tag0[1]};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef ASSERT_OFF
  a_center_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o == '0 && m_axis_tuser_o[0])
    else $error("origin beat without zero projection or inside flag");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  a_div_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld[0] == dv_vld[1] && dv_vld[0] == dv_vld[2])
    else $error("divider lanes out of step");
`endif

endmodule

// File: hw/rtl/ssp_norm.sv
module ssp_norm (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  ssp_pkg::coord_t [ssp_pkg::AXES-1:0]      pos_i,
  input  logic [ssp_pkg::RAD_W-1:0]                rad_i,
  output logic                                     valid_o,
  output logic [ssp_pkg::SQ_W-1:0]                 n2_o,
  output ssp_pkg::side_t                           side_o
);
  import ssp_pkg::*;

  // stage a: magnitudes
  coord_t [AXES-1:0]    mag_a_d, mag_a_q;
  logic   [AXES-1:0]    neg_a_d, neg_a_q;
  logic                 va_q;
  // stage b: squares
  logic [AXES-1:0][SQ_W-1:0] sq_b_q;
  coord_t [AXES-1:0]    mag_b_q;
  logic   [AXES-1:0]    neg_b_q;
  logic                 vb_q;
  // stage c: sum and compare
  logic [SQ_W-1:0]      n2_c_d, n2_c_q;
  side_t                side_c_q;
  logic                 vc_q;
  logic [RSQ_W-1:0]     rsq_q;

  for (genvar i = 0; i < AXES; i++) begin : g_abs
    if (i < DIMS) begin : g_used
      assign neg_a_d[i] = pos_i[i][COORD_W-1];
      assign mag_a_d[i] = neg_a_d[i] ? COORD_W'(-pos_i[i]) : pos_i[i];
    end else begin : g_unused
      assign neg_a_d[i] = 1'b0;
      assign mag_a_d[i] = '0;
    end
  end

  assign n2_c_d = sq_b_q[0] + sq_b_q[1] + sq_b_q[2];

  always_ff @(posedge clk_i) begin
    rsq_q <= RSQ_W'(rad_i) * RSQ_W'(rad_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= mag_a_d;
      neg_a_q <= neg_a_d;
      for (int i = 0; i < AXES; i++) begin
        sq_b_q[i] <= SQ_W'(mag_a_q[i]) * SQ_W'(mag_a_q[i]);
      end
      mag_b_q <= mag_a_q;
      neg_b_q <= neg_a_q;
      n2_c_q             <= n2_c_d;
      side_c_q.mag       <= mag_b_q;
      side_c_q.neg       <= neg_b_q;
      side_c_q.in_sphere <= n2_c_d <= SQ_W'(rsq_q);
      side_c_q.center    <= n2_c_d == '0;
    end
  end

  assign valid_o = vc_q;
  assign n2_o    = n2_c_q;
  assign side_o  = side_c_q;

endmodule

// File: hw/rtl/ssp_sqrt.sv
module ssp_sqrt #(
  parameter int unsigned TAG_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ssp_pkg::SQ_W-1:0]    rad_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic [ssp_pkg::ROOT_W-1:0]  root_o,
  output logic [TAG_W-1:0]            tag_o
);
  import ssp_pkg::*;

  localparam int unsigned N     = ROOT_W;   // one root bit per stage
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CUR_W = REM_W + 2;

  logic [SQ_W-1:0]   v_s    [N+1];
  logic [REM_W-1:0]  rem_s  [N+1];
  logic [ROOT_W-1:0] root_s [N+1];
  logic [TAG_W-1:0]  tag_s  [N+1];
  logic              vld_s  [N+1];

  assign v_s[0]    = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign tag_s[0]  = tag_i;
  assign vld_s[0]  = valid_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [CUR_W-1:0]  cur, trial;
    logic [REM_W-1:0]  rem_d, rem_q;
    logic [ROOT_W-1:0] root_d, root_q;
    logic [SQ_W-1:0]   v_q;
    logic [TAG_W-1:0]  tag_q;
    logic              vld_q;

    always_comb begin
      cur   = {rem_s[k], v_s[k][SQ_W-1 -: 2]};
      trial = {{(CUR_W-ROOT_W-2){1'b0}}, root_s[k], 2'b01};
      if (cur >= trial) begin
        rem_d  = REM_W'(cur - trial);
        root_d = {root_s[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(cur);
        root_d = {root_s[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        v_q    <= {v_s[k][SQ_W-3:0], 2'b00};
        tag_q  <= tag_s[k];
      end
    end

    assign v_s[k+1]    = v_q;
    assign rem_s[k+1]  = rem_q;
    assign root_s[k+1] = root_q;
    assign tag_s[k+1]  = tag_q;
    assign vld_s[k+1]  = vld_q;
  end

  assign valid_o = vld_s[N];
  assign root_o  = root_s[N];
  assign tag_o   = tag_s[N];

endmodule

// File: hw/rtl/ssp_div.sv
module ssp_div #(
  parameter int unsigned TAG_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ssp_pkg::PROD_W-1:0]  dividend_i,
  input  logic [ssp_pkg::ROOT_W-1:0]  divisor_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic [ssp_pkg::QUO_W-1:0]   quo_o,
  output logic [TAG_W-1:0]            tag_o
);
  import ssp_pkg::*;

  localparam int unsigned N = QUO_W;  // one quotient bit per stage

  // remainder starts as the dividend's top bits, which stay below the divisor away from the origin
  logic [ROOT_W-1:0] rem_s [N+1];
  logic [QUO_W-1:0]  low_s [N+1];
  logic [QUO_W-1:0]  quo_s [N+1];
  logic [ROOT_W-1:0] den_s [N+1];
  logic [TAG_W-1:0]  tag_s [N+1];
  logic              vld_s [N+1];

  assign rem_s[0] = dividend_i[PROD_W-1:QUO_W];
  assign low_s[0] = dividend_i[QUO_W-1:0];
  assign quo_s[0] = '0;
  assign den_s[0] = divisor_i;
  assign tag_s[0] = tag_i;
  assign vld_s[0] = valid_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [ROOT_W:0]   cur;
    logic [ROOT_W-1:0] rem_d, rem_q, den_q;
    logic [QUO_W-1:0]  quo_d, quo_q, low_q;
    logic [TAG_W-1:0]  tag_q;
    logic              vld_q;

    always_comb begin
      cur = {rem_s[k], low_s[k][QUO_W-1]};
      if (cur >= {1'b0, den_s[k]}) begin
        rem_d = ROOT_W'(cur - {1'b0, den_s[k]});
        quo_d = {quo_s[k][QUO_W-2:0], 1'b1};
      end else begin
        rem_d = cur[ROOT_W-1:0];
        quo_d = {quo_s[k][QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        low_q <= {low_s[k][QUO_W-2:0], 1'b0};
        den_q <= den_s[k];
        tag_q <= tag_s[k];
      end
    end

    assign rem_s[k+1] = rem_q;
    assign low_s[k+1] = low_q;
    assign quo_s[k+1] = quo_q;
    assign den_s[k+1] = den_q;
    assign tag_s[k+1] = tag_q;
    assign vld_s[k+1] = vld_q;
  end

  assign valid_o = vld_s[N];
  assign quo_o   = quo_s[N];
  assign tag_o   = tag_s[N];

endmodule

// File: tb/sphere_surface_project_tb.sv
`timescale 1ns / 100ps

module sphere_surface_project_tb;
  import ssp_pkg::*;

  localparam int unsigned LATENCY     = 68;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_POINTS = 600;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    coord_t  sx;
    coord_t  sy;
    coord_t  sz;
    logic    in_sphere;
    logic    center;
  } proj_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [RAD_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [95:0]      s_axis_tdata_i = '0;   // pos_x, pos_y, pos_z
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [95:0]      m_axis_tdata_o;        // surf_x, surf_y, surf_z
  logic [1:0]       m_axis_tuser_o;        // is_inside, at_center

  sphere_surface_project dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model copy of the radius register
  logic [RAD_W-1:0] radius_q = RESET_RADIUS;

  point_t pending_points[$];
  proj_t  expected_projs[$];
  int     errors = 0;
  int     cycles = 0;

  // sender pacing
  bit     send_hold = 1'b0;   // pause requested by stimulus
  bit     in_taken = 1'b0;    // input beat accepted at the last rising edge
  int     burst_left = 0;
  int     gap_left = 0;
  // receiver pacing
  int     long_stall = 0;     // long hold-off, set by stimulus
  int     stall_mode = 0;

  // bit-serial floor square root of a 64-bit value
  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [63:0] rem, res, b;
    rem = v;
    res = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  function automatic proj_t project_point(point_t p, logic [RAD_W-1:0] r);
    proj_t       o;
    coord_t      c[3];
    logic [63:0] mag[3];
    logic [63:0] q[3];
    logic [63:0] n2, rsq, norm;
    c[0] = p.x;
    c[1] = p.y;
    c[2] = p.z;
    n2 = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i][31] ? (64'h1_0000_0000 - {32'd0, c[i]}) : {32'd0, c[i]};
      if (i < DIMS) n2 += mag[i] * mag[i];
    end
    rsq = {33'd0, r} * {33'd0, r};
    o = '0;
    o.in_sphere = (n2 <= rsq);
    if (n2 == 0) begin
      o.center = 1'b1;
      return o;
    end
    norm = {32'd0, floor_sqrt(n2)};
    for (int i = 0; i < 3; i++) begin
      q[i] = (i < DIMS) ? ({33'd0, r} * mag[i]) / norm : 64'd0;
      if (c[i][31] && q[i] != 0) q[i] = 64'h1_0000_0000 - q[i];
    end
    o.sx = q[0][31:0];
    o.sy = q[1][31:0];
    o.sz = q[2][31:0];
    return o;
  endfunction

  // input acceptance, sampled at the rising edge
  always @(posedge clk_i) begin
    in_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (in_taken) begin
      expected_projs.push_back(project_point(pending_points.pop_front(), radius_q));
    end
  end

  // driver: bursts and gaps, data changes on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && !in_taken) begin
        // hold current beat
      end else if (pending_points.size() != 0 && !send_hold && gap_left == 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= pending_points[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 12);
      end else begin
        s_axis_tvalid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern, plus long hold-off on request
  always @(negedge clk_i) begin
    if (long_stall > 0) begin
      long_stall--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready_i <= ($urandom_range(0, 1) != 0);
        default: m_axis_tready_i <= (cycles % 5 < 2);
      endcase
    end
  end

  // monitor: result beats sampled at the rising edge
  always @(posedge clk_i) begin
    proj_t got, exp_p;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tdata_o[95:64],
             m_axis_tuser_o[0], m_axis_tuser_o[1]};
      if (expected_projs.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_p = expected_projs.pop_front();
        if (got.sx !== exp_p.sx) begin
          $error("surf_x exp %h got %h", exp_p.sx, got.sx);
          errors++;
        end
        if (got.sy !== exp_p.sy) begin
          $error("surf_y exp %h got %h", exp_p.sy, got.sy);
          errors++;
        end
        if (got.sz !== exp_p.sz) begin
          $error("surf_z exp %h got %h", exp_p.sz, got.sz);
          errors++;
        end
        if (got.in_sphere !== exp_p.in_sphere) begin
          $error("is_inside exp %b got %b", exp_p.in_sphere, got.in_sphere);
          errors++;
        end
        if (got.center !== exp_p.center) begin
          $error("at_center exp %b got %b", exp_p.center, got.center);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_points.size() != 0 || s_axis_tvalid_i || expected_projs.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_radius(logic [RAD_W-1:0] r);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    radius_q = r;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return coord_t'($urandom_range(0, 1 << 20)) - coord_t'(1 << 19);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      3: return 32'h8000_0000 | coord_t'($urandom_range(0, 3));
      4: return coord_t'($urandom_range(0, 3)) - 32'd1;
      default: return coord_t'($urandom_range(0, 1 << 24));
    endcase
  endfunction

  task automatic push_rand(int n);
    for (int i = 0; i < n; i++)
      pending_points.push_back('{z: rand_coord(), y: rand_coord(), x: rand_coord()});
  endtask

  initial begin
    logic [RAD_W-1:0] radii[6];
    radii = '{31'h7FFF_FFFF, 31'd0, 31'd1, 31'h0003_8000, 31'h0100_0000, 31'h2AAA_5555};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed points at reset radius (1.0)
    pending_points.push_back('{z: 0, y: 0, x: 0});                      // origin
    pending_points.push_back('{z: 0, y: 0, x: 32'h0001_0000});          // on sphere
    pending_points.push_back('{z: 0, y: 0, x: 32'h0001_0001});          // just outside
    pending_points.push_back('{z: 0, y: 32'hFFFF_0000, x: 0});          // -1.0 on y
    pending_points.push_back('{z: 32'h8000_0000, y: 0, x: 0});          // most negative
    pending_points.push_back('{z: 32'h8000_0000, y: 32'h8000_0000, x: 32'h8000_0000});
    pending_points.push_back('{z: 32'h7FFF_FFFF, y: 32'h7FFF_FFFF, x: 32'h7FFF_FFFF});
    pending_points.push_back('{z: 32'h7FFF_FFFF, y: 32'h8000_0000, x: 32'd1});
    pending_points.push_back('{z: 32'hFFFF_FFFF, y: 0, x: 0});          // tiny negative
    pending_points.push_back('{z: 32'd1, y: 32'd1, x: 32'd1});
    pending_points.push_back('{z: 32'h0000_8000, y: 32'hFFFF_8000, x: 32'h0000_8000});
    pending_points.push_back('{z: 32'h5555_5555, y: 32'hAAAA_AAAA, x: 32'h0F0F_F0F0});

    // max radius, then zero radius with origin and off-origin points
    set_radius(31'h7FFF_FFFF);
    pending_points.push_back('{z: 32'h7FFF_FFFF, y: 0, x: 0});
    pending_points.push_back('{z: 32'h8000_0000, y: 32'h8000_0000, x: 32'h8000_0000});
    pending_points.push_back('{z: 32'h0000_0001, y: 32'hFFFF_FFFF, x: 32'h0000_0001});
    set_radius(31'd0);
    pending_points.push_back('{z: 0, y: 0, x: 0});
    pending_points.push_back('{z: 0, y: 32'd1, x: 0});
    pending_points.push_back('{z: 32'h8000_0000, y: 0, x: 32'h7FFF_FFFF});

    // random phases across radii
    for (int p = 0; p < 6; p++) begin
      set_radius(radii[p]);
      push_rand(RAND_POINTS / 6);
      if (p == 2) begin
        // long receiver hold-off while the sender keeps offering
        long_stall = 400;
      end
      if (p == 4) begin
        // sender pause until everything has come back
        while (pending_points.size() > RAND_POINTS / 12) @(posedge clk_i);
        send_hold = 1'b1;
        while (s_axis_tvalid_i || expected_projs.size() != 0) @(posedge clk_i);
        send_hold = 1'b0;
      end
    end
    set_radius(RESET_RADIUS);
    push_rand(20);
    wait_drained();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
